// ===== hdl/assert_macros.svh =====
// assertion macros shared by the receiver rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define FPR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// expression must never be true outside reset
`define FPR_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define FPR_ASSERT(lbl, clk, rst, prop)
`define FPR_ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

// ===== hdl/fpr_pkg.sv =====
// shared constants and types of the framed packet receiver
// no dependencies; used by all receiver modules
package fpr_pkg;

   localparam logic [7:0] HDR1_BYTE    = 8'hB5;
   localparam logic [7:0] HDR2_BYTE    = 8'h5B;
   localparam logic [7:0] CMD_BYTE     = 8'h01;
   localparam logic [7:0] TRAILER_BYTE = 8'hBB;
   localparam logic [7:0] SUM_MODULUS  = 8'hFF;

   // parser phases, one-hot
   typedef enum logic [6:0] {
      PH_HUNT1 = 7'b0000001,
      PH_HUNT2 = 7'b0000010,
      PH_CMD   = 7'b0000100,
      PH_LEN   = 7'b0001000,
      PH_DATA  = 7'b0010000,
      PH_CHECK = 7'b0100000,
      PH_TRAIL = 7'b1000000
   } fpr_phase_type;

   // one result word
   typedef struct packed {
      logic       checksum_match;
      logic [7:0] first_value;
      logic [7:0] second_value;
   } fpr_result_type;

endpackage

// ===== hdl/fpr_channels.sv =====
// valid/ready channel interfaces for received bytes and parse results
// no dependencies
interface fpr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface fpr_rsp_if;
   logic       valid;
   logic       ready;
   logic       checksum_match;
   logic [7:0] first_value;
   logic [7:0] second_value;

   modport source (output valid, output checksum_match, output first_value,
                   output second_value, input ready);
   modport sink (input valid, input checksum_match, input first_value,
                 input second_value, output ready);
endinterface

// ===== hdl/fpr_in_stage.sv =====
// input register: holds one received byte until the parser takes it
// depends on fpr_pkg and fpr_req_if
module fpr_in_stage
   import fpr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   fpr_req_if.sink    req_port,
   input  logic       advance,
   output logic       item_valid,
   output logic [7:0] item_byte
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       take;

   // slot is free when empty or draining this cycle
   assign req_port.ready = !valid_ff || advance;
   assign take           = req_port.valid && req_port.ready;
   assign valid_in       = take ? 1'b1 : (advance ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req_port.rx_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;

endmodule

// ===== hdl/fpr_parser.sv =====
// frame hunter: phase machine, running sum, payload capture and checksum test
// depends on fpr_pkg
module fpr_parser
   import fpr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           item_fire,
   input  logic [7:0]     item_byte,
   output logic           at_check,
   output fpr_result_type result
);

   fpr_phase_type phase_ff, phase_in;
   logic [7:0]    sum_ff, sum_in;
   logic [7:0]    count_ff, count_in;
   logic [7:0]    length_ff, length_in;
   logic [7:0]    held_first_ff, held_first_in;
   logic [7:0]    held_second_ff, held_second_in;
   logic [7:0]    pend_first_ff, pend_first_in;
   logic [7:0]    pend_second_ff, pend_second_in;
   logic [7:0]    sum_mod;
   logic [7:0]    sum_add;
   logic [7:0]    count_inc;
   logic          match;

   // checksum test against the 8-bit running sum, with FF counted as zero
   assign sum_mod   = (sum_ff == SUM_MODULUS) ? 8'h00 : sum_ff;
   assign match     = (item_byte == sum_mod);
   assign sum_add   = sum_ff + item_byte;
   assign count_inc = count_ff + 8'd1;
   assign at_check  = (phase_ff == PH_CHECK);

   assign result.checksum_match = match;
   assign result.first_value    = match ? pend_first_ff : held_first_ff;
   assign result.second_value   = match ? pend_second_ff : held_second_ff;

   // next state for one byte
   always_comb begin
      phase_in       = phase_ff;
      sum_in         = sum_ff;
      count_in       = count_ff;
      length_in      = length_ff;
      held_first_in  = held_first_ff;
      held_second_in = held_second_ff;
      pend_first_in  = pend_first_ff;
      pend_second_in = pend_second_ff;
      case (phase_ff)
         PH_HUNT2: begin
            if (item_byte == HDR2_BYTE) begin
               sum_in   = sum_add;
               phase_in = PH_CMD;
            end else begin
               phase_in = PH_HUNT1;
               sum_in   = 8'h00;
               count_in = 8'h00;
            end
         end
         PH_CMD: begin
            if (item_byte == CMD_BYTE) begin
               sum_in   = sum_add;
               phase_in = PH_LEN;
            end else begin
               phase_in = PH_HUNT1;
               sum_in   = 8'h00;
               count_in = 8'h00;
            end
         end
         PH_LEN: begin
            length_in = item_byte;
            sum_in    = sum_add;
            count_in  = 8'h00;
            phase_in  = (item_byte == 8'h00) ? PH_CHECK : PH_DATA;
         end
         PH_DATA: begin
            if (count_ff == 8'd0) begin
               pend_first_in = item_byte;
            end else if (count_ff == 8'd1) begin
               pend_second_in = item_byte;
            end
            count_in = count_inc;
            sum_in   = sum_add;
            if (count_inc == length_ff) begin
               phase_in = PH_CHECK;
            end
         end
         PH_CHECK: begin
            if (match) begin
               held_first_in  = pend_first_ff;
               held_second_in = pend_second_ff;
            end
            sum_in   = 8'h00;
            count_in = 8'h00;
            phase_in = PH_TRAIL;
         end
         PH_TRAIL: begin
            if (item_byte == TRAILER_BYTE) begin
               phase_in = PH_HUNT1;
               sum_in   = 8'h00;
               count_in = 8'h00;
            end
         end
         default: begin
            // hunting first header byte, also any stray code
            if (item_byte == HDR1_BYTE) begin
               sum_in   = item_byte;
               count_in = 8'h00;
               phase_in = PH_HUNT2;
            end else begin
               phase_in = PH_HUNT1;
               sum_in   = 8'h00;
               count_in = 8'h00;
            end
         end
      endcase
   end

   // parser state, updated once per consumed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HUNT1;
         sum_ff         <= 8'h00;
         count_ff       <= 8'h00;
         held_first_ff  <= 8'h00;
         held_second_ff <= 8'h00;
         pend_first_ff  <= 8'h00;
         pend_second_ff <= 8'h00;
      end else if (item_fire) begin
         phase_ff       <= phase_in;
         sum_ff         <= sum_in;
         count_ff       <= count_in;
         held_first_ff  <= held_first_in;
         held_second_ff <= held_second_in;
         pend_first_ff  <= pend_first_in;
         pend_second_ff <= pend_second_in;
      end
   end

   // frame length is always written before it is read
   always_ff @(posedge clock) begin
      if (item_fire) begin
         length_ff <= length_in;
      end
   end

endmodule

// ===== hdl/fpr_out_stage.sv =====
// result register: holds one result word until the consumer takes it
// depends on fpr_pkg and fpr_rsp_if
module fpr_out_stage
   import fpr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           load,
   input  fpr_result_type result,
   output logic           out_free,
   fpr_rsp_if.source      rsp_port
);

   logic           valid_ff;
   logic           valid_in;
   fpr_result_type data_ff;

   assign out_free = !valid_ff || rsp_port.ready;
   assign valid_in = load ? 1'b1 : (rsp_port.ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_port.valid          = valid_ff;
   assign rsp_port.checksum_match = data_ff.checksum_match;
   assign rsp_port.first_value    = data_ff.first_value;
   assign rsp_port.second_value   = data_ff.second_value;

endmodule

// ===== hdl/framed_packet_receiver.sv =====
// Framed packet receiver. Takes one received byte per word on req_port and
// hunts for frames B5 5B 01 LEN payload CHK BB. One result word leaves on
// rsp_port for each checksum byte, carrying the match flag and the first two
// payload bytes of the last good frame. A byte is accepted every cycle while
// input is not stalled. An accepted checksum byte is registered in the input
// register, the parser tests it combinationally, and the result register then
// loads the result word, which is then valid on rsp_port for the consumer.
// A held result stalls input only when another checksum byte reaches the
// parser while the result register is still full.
// depends on fpr_pkg, fpr_channels, fpr_in_stage, fpr_parser, fpr_out_stage
`include "assert_macros.svh"
module framed_packet_receiver
   import fpr_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   fpr_req_if.sink   req_port,
   fpr_rsp_if.source rsp_port
);

   logic           item_valid;
   logic [7:0]     item_byte;
   logic           advance;
   logic           item_fire;
   logic           at_check;
   logic           emit;
   logic           out_free;
   logic           out_load;
   fpr_result_type result;

   // a byte moves on unless it must emit and the result slot is full
   assign emit      = item_valid && at_check;
   assign advance   = !emit || out_free;
   assign item_fire = item_valid && advance;
   assign out_load  = emit && out_free;

   fpr_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_port   (req_port),
      .advance    (advance),
      .item_valid (item_valid),
      .item_byte  (item_byte)
   );

   fpr_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .item_fire (item_fire),
      .item_byte (item_byte),
      .at_check  (at_check),
      .result    (result)
   );

   fpr_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (out_load),
      .result   (result),
      .out_free (out_free),
      .rsp_port (rsp_port)
   );

   // checks
   `FPR_ASSERT(a_load_shows, clock, reset, out_load |=> rsp_port.valid)
   `FPR_ASSERT_NEVER(a_no_overrun, clock, reset, req_port.ready && item_valid && !advance)
   `FPR_ASSERT_NEVER(a_stall_only_check, clock, reset, item_valid && !advance && !at_check)

endmodule
